FILE: rtl/mebq_pkg.sv
// Shared constants, codes and types of the MAC exponential backoff queue.
package mebq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int OPCODE_W = 3;
  localparam int EVT_W    = 32;
  localparam int RND_W    = 15;
  localparam int SLOT_W   = 16;
  localparam int LIMIT_W  = 4;
  localparam int CTR_W    = 4;
  localparam int QCNT_W   = 5;
  localparam int DROP_W   = 32;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [OPCODE_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUCCESS = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_COLL    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_BUSY_P  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_BUSY_NP = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

  localparam logic [SLOT_W-1:0]  SLOT_RESET  = 16'd512;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

  // Commands broadcast to every cell of the queue row.
  typedef struct packed {
    logic shift;   // take the right neighbor's time (pop head)
    logic write;   // load the push time where selected
  } cell_ctl_t;

endpackage

FILE: rtl/mebq_if.sv
// Valid/ready channel interfaces for queue commands and queue status results.
interface mebq_in_if;
  logic                          valid;
  logic                          ready;
  logic [mebq_pkg::OPCODE_W-1:0] opcode;
  logic [mebq_pkg::EVT_W-1:0]    event_time;
  logic [mebq_pkg::RND_W-1:0]    random_bits;

  modport source (output valid, opcode, event_time, random_bits, input ready);
  modport sink   (input valid, opcode, event_time, random_bits, output ready);
endinterface

interface mebq_out_if;
  logic                        valid;
  logic                        ready;
  logic [mebq_pkg::EVT_W-1:0]  head_time;
  logic [mebq_pkg::QCNT_W-1:0] queue_count;
  logic                        dropped_now;
  logic [mebq_pkg::DROP_W-1:0] dropped_total;
  logic [mebq_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, head_time, queue_count, dropped_now, dropped_total,
                  error_code, input ready);
  modport sink   (input valid, head_time, queue_count, dropped_now, dropped_total,
                  error_code, output ready);
endinterface

FILE: rtl/mac_exponential_backoff_queue_top.sv
// Push, success, drop and error commands go from IDLE through EXEC to FIN, which loads the result register.
// Collision and busy commands that raise go through EXEC, ADD and SWEEP to FIN: the raise
// sweep walks the cell row one cell per cycle. FIN waits while a held result is not taken.
// One command at a time: a new command is taken only in IDLE, after FIN has loaded the result.
// Reset: control and counters cleared, config registers set to slot 512, limit 10;
// queue times are undefined until pushed, with no clearing pass.
module mac_exponential_backoff_queue_top #(
  parameter int QUEUE_DEPTH = mebq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = mebq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mebq_in_if.sink                        in_ch,
  mebq_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [mebq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mebq_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import mebq_pkg::*;

  localparam int HC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW_W  = $clog2(QUEUE_DEPTH);
  localparam int ET_WW = TIME_BITS + EVT_W;
  localparam int HQ_WW = HC_W + QCNT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_ADD   = 6'b000100,
    S_SWEEP = 6'b001000,
    S_FIN   = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Config registers.
  logic [SLOT_W-1:0]  slot_r;
  logic [LIMIT_W-1:0] limit_r;

  // Latched command.
  logic [OPCODE_W-1:0]  op_r;
  logic [TIME_BITS-1:0] et_r;
  logic [RND_W-1:0]     rnd_r;

  // Queue control state.
  logic [HC_W-1:0]   held_r, held_nxt;
  logic [CTR_W-1:0]  coll_r, coll_nxt;
  logic [CTR_W-1:0]  busy_r, busy_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic              drop_now_r, drop_now_nxt;
  logic [SW_W-1:0]   sweep_cnt_r, sweep_cnt_nxt;

  // Output register.
  logic              out_valid_r;
  logic [EVT_W-1:0]  out_head_r;
  logic [QCNT_W-1:0] out_qcnt_r;
  logic              out_drop_now_r;
  logic [DROP_W-1:0] out_drop_total_r;
  logic [ERR_W-1:0]  out_err_r;

  logic              in_xfer;
  logic              out_load;
  logic [ET_WW-1:0]  et_wide;
  logic [TIME_BITS-1:0] et_sat;
  logic [TIME_BITS-1:0] time_max;

  cell_ctl_t         cell_ctl;
  logic              bo_load;
  logic              bo_zero;
  logic [TIME_BITS-1:0] bo_base;
  logic [CTR_W-1:0]  sel_ctr;
  logic [CTR_W-1:0]  ctr_inc;
  logic [TIME_BITS-1:0] target_r;
  logic              sweep_go;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] wr_sel;
  logic [QUEUE_DEPTH-1:0] go_out;
  logic [TIME_BITS-1:0]   tgt_out [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   cell_val [QUEUE_DEPTH];
  logic [TIME_BITS+EVT_W-1:0] head_wide;
  logic [HQ_WW-1:0]       held_wide;

  // ---------------------------------------------------------------------------
  // Handshakes: take a command only when idle; the output register parts the
  // result side, so a waiting result does not block the next transfer.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Clamp the event time into the internal time width.
  assign time_max = '1;
  assign et_wide  = ET_WW'(in_ch.event_time);
  assign et_sat   = (et_wide > ET_WW'(time_max)) ? time_max : et_wide[TIME_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Configuration writes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= SLOT_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_TICKS:  slot_r  <= cfg_wdata[SLOT_W-1:0];
        REG_RETRY_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the command on transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_ch.opcode;
      et_r  <= et_sat;
      rnd_r <= in_ch.random_bits;
    end
  end

  // Counter chosen by the backoff command and its incremented value.
  assign sel_ctr = (op_r == OP_COLL) ? coll_r : busy_r;
  assign ctr_inc = sel_ctr + CTR_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer. EXEC decides the command against the held count and the head;
  // pushes and pops finish there, raises go through ADD and a full SWEEP.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    coll_nxt      = coll_r;
    busy_nxt      = busy_r;
    drop_nxt      = drop_r;
    err_nxt       = err_r;
    drop_now_nxt  = drop_now_r;
    sweep_cnt_nxt = sweep_cnt_r;
    cell_ctl      = '0;
    bo_load       = 1'b0;
    bo_zero       = 1'b0;
    bo_base       = et_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          err_nxt      = ERR_OK;
          drop_now_nxt = 1'b0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (op_r)
          OP_PUSH: begin
            if (held_r >= HC_W'(QUEUE_DEPTH)) begin
              err_nxt = ERR_FULL;
            end else begin
              cell_ctl.write = 1'b1;
              held_nxt       = held_r + HC_W'(1);
            end
          end
          OP_SUCCESS: begin
            if (held_r == '0) begin
              err_nxt = ERR_EMPTY;
            end else begin
              cell_ctl.shift = 1'b1;
              held_nxt       = held_r - HC_W'(1);
              coll_nxt       = '0;
              busy_nxt       = '0;
            end
          end
          OP_COLL, OP_BUSY_NP: begin
            if (held_r == '0) begin
              err_nxt = ERR_EMPTY;
            end else if (sel_ctr >= limit_r) begin
              // Retry limit reached: drop the head and count it.
              cell_ctl.shift = 1'b1;
              held_nxt       = held_r - HC_W'(1);
              coll_nxt       = '0;
              busy_nxt       = '0;
              drop_now_nxt   = 1'b1;
              if (drop_r != '1) begin
                drop_nxt = drop_r + DROP_W'(1);
              end
            end else begin
              if (op_r == OP_COLL) begin
                coll_nxt = ctr_inc;
              end else begin
                busy_nxt = ctr_inc;
                bo_base  = cell_val[0];
              end
              bo_load   = 1'b1;
              state_nxt = S_ADD;
            end
          end
          OP_BUSY_P: begin
            // Raise to the event time itself: zero delay.
            bo_load   = 1'b1;
            bo_zero   = 1'b1;
            state_nxt = S_ADD;
          end
          default: ;
        endcase
      end
      S_ADD: begin
        sweep_cnt_nxt = '0;
        state_nxt     = S_SWEEP;
      end
      S_SWEEP: begin
        // The sweep front reaches cell k when the sweep counter equals k; stop after the last cell.
        sweep_cnt_nxt = sweep_cnt_r + SW_W'(1);
        if (sweep_cnt_r == SW_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      coll_r      <= '0;
      busy_r      <= '0;
      drop_r      <= '0;
      err_r       <= ERR_OK;
      drop_now_r  <= 1'b0;
      sweep_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      coll_r      <= coll_nxt;
      busy_r      <= busy_nxt;
      drop_r      <= drop_nxt;
      err_r       <= err_nxt;
      drop_now_r  <= drop_now_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Backoff target: product registered in EXEC, saturated sum ready in SWEEP.
  // ---------------------------------------------------------------------------
  mebq_backoff #(
    .TIME_BITS (TIME_BITS)
  ) u_backoff (
    .clk        (clk),
    .load       (bo_load),
    .zero_delay (bo_zero),
    .base       (bo_base),
    .slot       (slot_r),
    .rnd        (rnd_r),
    .count      (ctr_inc),
    .target_r   (target_r)
  );

  // ---------------------------------------------------------------------------
  // Cell row, head at cell 0. Each cell passes the raise front and the target
  // to its right neighbor every cycle; a pop shifts every time one cell left.
  // ---------------------------------------------------------------------------
  assign sweep_go = (state_r == S_SWEEP) && (sweep_cnt_r == '0);

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                 go_in;
    logic [TIME_BITS-1:0] tgt_in;
    logic [TIME_BITS-1:0] nbr_val;

    assign occ[k]    = (held_r > HC_W'(k));
    assign wr_sel[k] = (held_r == HC_W'(k));

    if (k == 0) begin : g_first
      assign go_in  = sweep_go;
      assign tgt_in = target_r;
    end else begin : g_rest
      assign go_in  = go_out[k-1];
      assign tgt_in = tgt_out[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_val = cell_val[k];
    end else begin : g_inner
      assign nbr_val = cell_val[k+1];
    end

    mebq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (cell_ctl),
      .wr_sel       (wr_sel[k]),
      .occupied     (occ[k]),
      .wr_data      (et_r),
      .next_value   (nbr_val),
      .go_in        (go_in),
      .target_in    (tgt_in),
      .go_out_r     (go_out[k]),
      .target_out_r (tgt_out[k]),
      .value_r      (cell_val[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: load in FIN from the settled queue state.
  // ---------------------------------------------------------------------------
  assign head_wide = (TIME_BITS+EVT_W)'(cell_val[0]);
  assign held_wide = HQ_WW'(held_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_head_r       <= (held_r != '0) ? head_wide[EVT_W-1:0] : '0;
      out_qcnt_r       <= held_wide[QCNT_W-1:0];
      out_drop_now_r   <= drop_now_r;
      out_drop_total_r <= drop_r;
      out_err_r        <= err_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.head_time     = out_head_r;
  assign out_ch.queue_count   = out_qcnt_r;
  assign out_ch.dropped_now   = out_drop_now_r;
  assign out_ch.dropped_total = out_drop_total_r;
  assign out_ch.error_code    = out_err_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HC_W'(QUEUE_DEPTH))
    else $error("held count above queue depth");

  a_held_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(held_r))
    else $error("held count changed outside command decode");

  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> (state_r == S_SWEEP) && (sweep_cnt_r == '0))
    else $error("raise sweep did not start from the head cell");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && drop_now_nxt |=> (coll_r == '0) && (busy_r == '0)
      && drop_now_r)
    else $error("drop did not clear retry counters");

endmodule

FILE: rtl/mebq_cell.sv
// One queue cell: holds a ready time, shifts toward the head, raises on a passing sweep.
module mebq_cell #(
  parameter int TIME_BITS = mebq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mebq_pkg::cell_ctl_t  ctl,
  input  logic                 wr_sel,
  input  logic                 occupied,
  input  logic [TIME_BITS-1:0] wr_data,
  input  logic [TIME_BITS-1:0] next_value,
  input  logic                 go_in,
  input  logic [TIME_BITS-1:0] target_in,
  output logic                 go_out_r,
  output logic [TIME_BITS-1:0] target_out_r,
  output logic [TIME_BITS-1:0] value_r
);
  import mebq_pkg::*;

  logic raise;

  assign raise = go_in && occupied && (value_r < target_in);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r <= next_value;
    end else if (ctl.write && wr_sel) begin
      value_r <= wr_data;
    end else if (raise) begin
      value_r <= target_in;
    end
    target_out_r <= target_in;
  end

  // Hand the sweep on only while times keep being raised.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_out_r <= 1'b0;
    end else begin
      go_out_r <= raise;
    end
  end

endmodule

FILE: rtl/mebq_backoff.sv
// Backoff target: slot times masked random, registered product, saturating add.
module mebq_backoff #(
  parameter int TIME_BITS = mebq_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          zero_delay,
  input  logic [TIME_BITS-1:0]          base,
  input  logic [mebq_pkg::SLOT_W-1:0]   slot,
  input  logic [mebq_pkg::RND_W-1:0]    rnd,
  input  logic [mebq_pkg::CTR_W-1:0]    count,
  output logic [TIME_BITS-1:0]          target_r
);
  import mebq_pkg::*;

  localparam int PROD_W = SLOT_W + RND_W;
  localparam int SUM_W  = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

  logic [RND_W:0]          mask_full;
  logic [RND_W-1:0]        masked;
  logic [PROD_W-1:0]       product_r;
  logic [TIME_BITS-1:0]    base_r;
  logic [SUM_W-1:0]        sum;
  logic [TIME_BITS-1:0]    time_max;

  assign mask_full = ((RND_W+1)'(1) << count) - (RND_W+1)'(1);
  assign masked    = zero_delay ? '0 : (rnd & mask_full[RND_W-1:0]);
  assign time_max  = '1;

  always_ff @(posedge clk) begin
    if (load) begin
      product_r <= PROD_W'(slot) * PROD_W'(masked);
      base_r    <= base;
    end
  end

  assign sum = SUM_W'(base_r) + SUM_W'(product_r);

  // Clamp at the largest time.
  always_ff @(posedge clk) begin
    target_r <= (sum > SUM_W'(time_max)) ? time_max : sum[TIME_BITS-1:0];
  end

endmodule
